FILE: sv/nafu_pkg.sv
// Shared constants, types and exponential lookup tables for the activation unit
`default_nettype none

package nafu_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int MODE_W     = 3;

    // exponent argument: up to 2*|x| for tanh
    localparam int EXP_W = DATA_WIDTH + 1;

    // Q.31 internal exponent format
    localparam int IQ    = 31;
    localparam int Q31_W = IQ + 1;

    // argument split: integer part, upper and lower fraction halves
    localparam int LO_W  = FRAC_BITS / 2;
    localparam int MID_W = FRAC_BITS - LO_W;
    localparam int HI_W  = 5;
    localparam int LO_N  = 2 ** LO_W;
    localparam int MID_N = 2 ** MID_W;
    localparam int HI_N  = 2 ** HI_W;

    // weight of one input LSB
    localparam real FIX_LSB = 1.0 / (2.0 ** FRAC_BITS);

    // divider
    localparam int DEN_W      = Q31_W + 1;
    localparam int REM_W      = DEN_W;
    localparam int QF         = 27;
    localparam int QW         = QF + 1;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QW / DIV_BITS;

    // output rounding
    localparam int RND_SH = QF - FRAC_BITS;
    localparam int RND_W  = QW - RND_SH + 1;

    localparam logic [Q31_W-1:0] Q31_ONE  = Q31_W'(64'd1 << IQ);
    localparam logic [Q31_W-1:0] Q31_HALF = Q31_W'(64'd1 << (IQ - 1));
    localparam logic [REM_W-1:0] REM_INIT = REM_W'(64'd1 << (IQ - 1));
    localparam logic [QW-1:0]    QF_ONE   = QW'(64'd1 << QF);
    localparam logic [QW-1:0]    QF_HALF  = QW'(64'd1 << (QF - 1));
    localparam logic [QW-1:0]    QF_TENTH = QW'(longint'(0.1 * (2.0 ** QF)));
    localparam logic [QW-1:0]    RND_HALF = QW'(64'd1 << (RND_SH - 1));

    localparam logic [DATA_WIDTH-1:0] OUT_MAXPOS =
        DATA_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [DATA_WIDTH-1:0] OUT_MINNEG = OUT_MAXPOS + 1'b1;
    localparam logic [DATA_WIDTH-1:0] OUT_ONE =
        (FRAC_BITS < DATA_WIDTH - 1) ? DATA_WIDTH'(64'd1 << FRAC_BITS) : OUT_MAXPOS;

    typedef enum logic [MODE_W-1:0] {
        MODE_SIGMOID    = 3'd0,
        MODE_SIG_DERIV  = 3'd1,
        MODE_TANH       = 3'd2,
        MODE_TANH_DERIV = 3'd3,
        MODE_RELU       = 3'd4,
        MODE_RELU_DERIV = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic                  neg;
        logic [DATA_WIDTH-1:0] direct;
    } ctrl_t;

    typedef logic [Q31_W-1:0] q31_t;
    typedef q31_t lo_tab_t  [LO_N];
    typedef q31_t mid_tab_t [MID_N];
    typedef q31_t hi_tab_t  [HI_N];

    function automatic q31_t exp_q31(real a);
        return q31_t'(longint'($exp(-a) * (2.0 ** IQ)));
    endfunction

    function automatic lo_tab_t build_lo_tab();
        lo_tab_t tab;
        for (int i = 0; i < LO_N; i++)
        begin
            tab[i] = exp_q31(real'(i) * FIX_LSB);
        end
        return tab;
    endfunction

    function automatic mid_tab_t build_mid_tab();
        mid_tab_t tab;
        for (int i = 0; i < MID_N; i++)
        begin
            tab[i] = exp_q31(real'(i * (2 ** LO_W)) * FIX_LSB);
        end
        return tab;
    endfunction

    function automatic hi_tab_t build_hi_tab();
        hi_tab_t tab;
        for (int i = 0; i < HI_N; i++)
        begin
            tab[i] = exp_q31(real'(i));
        end
        return tab;
    endfunction

    localparam lo_tab_t  EXP_LO_TAB  = build_lo_tab();
    localparam mid_tab_t EXP_MID_TAB = build_mid_tab();
    localparam hi_tab_t  EXP_HI_TAB  = build_hi_tab();

endpackage

`default_nettype wire

FILE: sv/nafu_exp.sv
// Three-stage exp(-a) pipeline: table lookups and two rounded Q.31 products
`default_nettype none

module nafu_exp
    import nafu_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              en,
    input  wire              in_valid,
    input  wire [EXP_W-1:0]  arg,
    input  wire ctrl_t       in_ctrl,
    output logic             out_valid,
    output logic [Q31_W-1:0] exp_val,
    output ctrl_t            out_ctrl
);

    localparam int PROD_W = 2 * Q31_W;

    logic [2:0]       vld_reg;
    ctrl_t            c1_reg, c2_reg, c3_reg;
    logic [Q31_W-1:0] th_reg, tm_reg, tl_reg, tl2_reg, p_reg, e_reg;
    logic [Q31_W-1:0] p_next, e_next;
    logic [HI_W-1:0]  hi_idx;
    logic             arg_big;
    logic [PROD_W-1:0] prod_a, prod_b;

    if (EXP_W > FRAC_BITS + HI_W)
    begin : g_clamp
        assign arg_big = |arg[EXP_W-1:FRAC_BITS+HI_W];
    end
    else
    begin : g_noclamp
        assign arg_big = 1'b0;
    end

    assign hi_idx = arg_big ? {HI_W{1'b1}} : arg[FRAC_BITS+HI_W-1:FRAC_BITS];

    always_comb
    begin
        prod_a = th_reg * tm_reg;
        p_next = Q31_W'((prod_a + PROD_W'(Q31_HALF)) >> IQ);
        prod_b = p_reg * tl2_reg;
        e_next = Q31_W'((prod_b + PROD_W'(Q31_HALF)) >> IQ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_reg  <= EXP_HI_TAB[hi_idx];
            tm_reg  <= EXP_MID_TAB[arg[FRAC_BITS-1:LO_W]];
            tl_reg  <= EXP_LO_TAB[arg[LO_W-1:0]];
            c1_reg  <= in_ctrl;
            p_reg   <= p_next;
            tl2_reg <= tl_reg;
            c2_reg  <= c1_reg;
            e_reg   <= e_next;
            c3_reg  <= c2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign exp_val   = e_reg;
    assign out_ctrl  = c3_reg;

endmodule

`default_nettype wire

FILE: sv/nafu_div.sv
// Pipelined restoring divider forming 1/(1+e), two quotient bits per stage
`default_nettype none

module nafu_div
    import nafu_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              en,
    input  wire              in_valid,
    input  wire [Q31_W-1:0]  exp_val,
    input  wire ctrl_t       in_ctrl,
    output logic             out_valid,
    output logic [QW-1:0]    quo,
    output ctrl_t            out_ctrl
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [REM_W-1:0]      rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg  [DIV_STAGES];
    logic [QW-1:0]         quo_reg  [DIV_STAGES];
    ctrl_t                 ctrl_reg [DIV_STAGES];

    logic [REM_W-1:0] rem_in   [DIV_STAGES];
    logic [DEN_W-1:0] den_in   [DIV_STAGES];
    logic [QW-1:0]    quo_in   [DIV_STAGES];
    ctrl_t            ctrl_in  [DIV_STAGES];
    logic [REM_W-1:0] rem_next [DIV_STAGES];
    logic [QW-1:0]    quo_next [DIV_STAGES];

    always_comb
    begin
        rem_in[0]  = REM_INIT;
        den_in[0]  = {1'b0, exp_val} + {1'b0, Q31_ONE};
        quo_in[0]  = '0;
        ctrl_in[0] = in_ctrl;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            rem_in[s]  = rem_reg[s-1];
            den_in[s]  = den_reg[s-1];
            quo_in[s]  = quo_reg[s-1];
            ctrl_in[s] = ctrl_reg[s-1];
        end
    end

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [REM_W:0]   trial;
        logic [QW-1:0]    q;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            r = rem_in[s];
            q = quo_in[s];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                trial = {r, 1'b0};
                if (trial >= {1'b0, den_in[s]})
                begin
                    r = REM_W'(trial - {1'b0, den_in[s]});
                    q = {q[QW-2:0], 1'b1};
                end
                else
                begin
                    r = trial[REM_W-1:0];
                    q = {q[QW-2:0], 1'b0};
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_in[s];
                quo_reg[s]  <= quo_next[s];
                ctrl_reg[s] <= ctrl_in[s];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo       = quo_reg[DIV_STAGES-1];
    assign out_ctrl  = ctrl_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/nafu_post.sv
// Three-stage back end: per-mode product, offset, rounding and saturation
`default_nettype none

module nafu_post
    import nafu_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   in_valid,
    input  wire [QW-1:0]          quo,
    input  wire ctrl_t            in_ctrl,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int PROD_W = 2 * QW;
    localparam int CMP_W  = (RND_W > DATA_WIDTH) ? RND_W : DATA_WIDTH;

    logic [2:0]            vld_reg;
    ctrl_t                 c1_reg, c2_reg;
    logic [QW-1:0]         lin_reg, val_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DATA_WIDTH-1:0] res_reg;

    logic [QW-1:0]         qc, t, lin_next, ma, mb, prod_rnd, val_next;
    logic [PROD_W-1:0]     prod_next;
    logic [RND_W-1:0]      rnd;
    logic                  big;
    logic [DATA_WIDTH-1:0] pos_val, neg_val, res_next;

    // stage 1: 1-q, 2q-1 and the single product
    always_comb
    begin
        qc = QF_ONE - quo;
        t  = QW'({1'b0, quo, 1'b0} - {2'b0, QF_ONE});
        case (in_ctrl.mode)
            MODE_SIGMOID: lin_next = in_ctrl.neg ? qc : quo;
            MODE_TANH:    lin_next = t;
            default:      lin_next = quo;
        endcase
        if (in_ctrl.mode == MODE_TANH_DERIV)
        begin
            ma = t;
            mb = t;
        end
        else
        begin
            ma = quo;
            mb = qc;
        end
        prod_next = ma * mb;
    end

    // stage 2: value in Q.QF
    always_comb
    begin
        prod_rnd = QW'((prod_reg + PROD_W'(QF_HALF)) >> QF);
        case (c1_reg.mode)
            MODE_SIG_DERIV:  val_next = prod_rnd + QF_TENTH;
            MODE_TANH_DERIV: val_next = QF_ONE - prod_rnd;
            default:         val_next = lin_reg;
        endcase
    end

    // stage 3: round to output format, saturate, apply sign
    always_comb
    begin
        rnd     = RND_W'(({1'b0, val_reg} + {1'b0, RND_HALF}) >> RND_SH);
        big     = CMP_W'(rnd) > CMP_W'(OUT_MAXPOS);
        pos_val = big ? OUT_MAXPOS : DATA_WIDTH'(rnd);
        neg_val = big ? OUT_MINNEG : DATA_WIDTH'(0) - DATA_WIDTH'(rnd);
        case (c2_reg.mode) inside
            MODE_SIGMOID, MODE_SIG_DERIV, MODE_TANH_DERIV: res_next = pos_val;
            MODE_TANH: res_next = c2_reg.neg ? neg_val : pos_val;
            default:   res_next = c2_reg.direct;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg  <= lin_next;
            prod_reg <= prod_next;
            c1_reg   <= in_ctrl;
            val_reg  <= val_next;
            c2_reg   <= c1_reg;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign result    = res_reg;

    a_tanh_deriv_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] && c2_reg.mode == MODE_TANH_DERIV |-> val_reg <= QF_ONE)
        else $error("tanh derivative above one");

    a_sigmoid_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[1] && c2_reg.mode == MODE_SIGMOID |=> !res_reg[DATA_WIDTH-1])
        else $error("negative sigmoid result");

    a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[0] |=> vld_reg[1])
        else $error("valid lost between back end stages");

endmodule

`default_nettype wire

FILE: sv/neural_activation_function_unit.sv
// Top level of the element-wise activation unit: mode register and pipeline
// Pipeline: 20 register stages from s_axis_tdata to m_axis_tdata.
// Throughput: one word per cycle while en; each stage (14-stage divider too) takes a new word.
// Flow control: the whole pipeline advances unless the output word is held by tready low.
// Reset: rst_n clears all valid bits and sets mode to sigmoid; data registers are not reset.
`default_nettype none

module neural_activation_function_unit
    import nafu_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire [DATA_WIDTH-1:0]  s_axis_tdata,   // [15:0] sample_in
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [DATA_WIDTH-1:0] m_axis_tdata,   // [15:0] sample_out
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [MODE_W-1:0]      cfg_data        // mode
);

    mode_t                 mode_reg;
    logic                  en;
    logic                  neg, positive;
    logic [DATA_WIDTH-1:0] mag;
    logic [EXP_W-1:0]      arg;
    ctrl_t                 in_ctrl;

    logic             exp_valid, div_valid;
    logic [Q31_W-1:0] exp_val;
    ctrl_t            exp_ctrl, div_ctrl;
    logic [QW-1:0]    quo;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SIGMOID;
        else if (cfg_valid)
            mode_reg <= mode_t'(cfg_data);
    end

    always_comb
    begin
        neg      = s_axis_tdata[DATA_WIDTH-1];
        positive = !neg && (|s_axis_tdata);
        mag      = neg ? DATA_WIDTH'(0) - s_axis_tdata : s_axis_tdata;
        if (mode_reg == MODE_TANH || mode_reg == MODE_TANH_DERIV)
            arg = {mag, 1'b0};
        else
            arg = {1'b0, mag};
        in_ctrl.mode = mode_reg;
        in_ctrl.neg  = neg;
        case (mode_reg)
            MODE_RELU:       in_ctrl.direct = positive ? s_axis_tdata : '0;
            MODE_RELU_DERIV: in_ctrl.direct = positive ? OUT_ONE : '0;
            default:         in_ctrl.direct = '0;
        endcase
    end

    nafu_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .arg       (arg),
        .in_ctrl   (in_ctrl),
        .out_valid (exp_valid),
        .exp_val   (exp_val),
        .out_ctrl  (exp_ctrl)
    );

    nafu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (exp_valid),
        .exp_val   (exp_val),
        .in_ctrl   (exp_ctrl),
        .out_valid (div_valid),
        .quo       (quo),
        .out_ctrl  (div_ctrl)
    );

    nafu_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .quo       (quo),
        .in_ctrl   (div_ctrl),
        .out_valid (m_axis_tvalid),
        .result    (m_axis_tdata)
    );

endmodule

`default_nettype wire
